@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ src/pds_pkg.sv @@
package pds_pkg;
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned COUNT_W = 19;
  localparam int unsigned SQ_W    = 34;
  localparam int unsigned DSUM_W  = 35;
  localparam int unsigned SSUM_W  = 52;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic               final_pair;
  } pds_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic               stats_valid;
    logic [COUNT_W-1:0] pair_count;
    logic [DIST_W-1:0]  min_distance;
    logic [DIST_W-1:0]  max_distance;
    logic [DIST_W-1:0]  mean_distance;
    logic [DIST_W-1:0]  rms_distance;
    logic               overflowed;
  } pds_out_t;

  // Job handed from the front to the back.
  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            final_pair;
  } pds_job_t;
endpackage

@@ src/pds_front.sv @@
// Computes the squared distance of a pair; registered stage with skid-free stall.
module pds_front #(
  parameter int COORD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pds_pkg::pds_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output pds_pkg::pds_job_t job_data
);
  import pds_pkg::*;

  logic              valid_r;
  pds_job_t          job_r;
  logic [SQ_W-1:0]   sq_nxt;
  logic signed [COORD_BITS:0] dx, dy, dz;

  function automatic logic signed [COORD_BITS:0] diff(logic [15:0] a, logic [15:0] b);
    logic signed [COORD_BITS-1:0] sa, sb;
    sa = a[COORD_BITS-1:0];
    sb = b[COORD_BITS-1:0];
    return (COORD_BITS+1)'(sa) - (COORD_BITS+1)'(sb);
  endfunction

  assign dx = diff(in_data.first_x, in_data.second_x);
  assign dy = diff(in_data.first_y, in_data.second_y);
  assign dz = diff(in_data.first_z, in_data.second_z);

  // The products are sized by the left-hand side, so the factors are sign
  // extended to the full product width before the multiply.
  always_comb begin
    logic signed [2*COORD_BITS+1:0] px, py, pz;
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
    sq_nxt = SQ_W'(px) + SQ_W'(py) + SQ_W'(pz);
  end

  assign in_ready  = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job_data  = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      job_r.sq         <= sq_nxt;
      job_r.final_pair <= in_data.final_pair;
    end
  end
endmodule

@@ src/pds_queue.sv @@
// Two-entry queue between front and back.
module pds_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  pds_pkg::pds_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output pds_pkg::pds_job_t rd_data
);
  import pds_pkg::*;

  pds_job_t   mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rptr_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) wptr_r <= !wptr_r;
      if (rd_en) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) mem_r[wptr_r] <= wr_data;
  end
endmodule

@@ src/pds_back.sv @@
// Sequencer: root of the pair, accumulate, and on the last pair divide twice
// and take one more root. Shared restoring units work one bit per cycle.
`include "assert_macros.svh"
module pds_back #(
  parameter int MAX_POINTS = 262144
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  pds_pkg::pds_job_t job_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pds_pkg::pds_out_t out_data
);
  import pds_pkg::*;

  localparam int unsigned REM_W      = COUNT_W + 1;
  localparam int unsigned ROOT_STEPS = SQ_W / 2;

  typedef enum logic [2:0] {
    S_IDLE, S_ROOT, S_ACC, S_DIV1, S_DIV2, S_ROOT2, S_OUT
  } state_t;

  state_t              state_r;
  logic [SQ_W-1:0]     op_r;      // root operand, rotated two bits per step
  logic [REM_W-1:0]    rem_r;     // root or division partial remainder
  logic [DIST_W-1:0]   root_r;
  logic [SSUM_W-1:0]   quo_r;
  logic [5:0]          step_r;
  logic                final_r;
  logic [COUNT_W-1:0]  count_r;
  logic [DIST_W-1:0]   min_r, max_r;
  logic [DSUM_W-1:0]   dsum_r;
  logic [SSUM_W-1:0]   ssum_r;
  logic                ovf_r;
  logic [DIST_W-1:0]   dist_r, mean_r;
  pds_out_t            out_r;
  logic                out_valid_r;
  pds_out_t            out_nxt;
  logic                out_load;

  logic [REM_W-1:0]    root_shift, root_trial, root_rem_nxt;
  logic                root_bit;
  logic [DIST_W-1:0]   root_nxt;
  logic                div_in;
  logic [REM_W-1:0]    div_shift, div_rem_nxt;
  logic                div_bit;
  logic [SSUM_W-1:0]   quo_nxt;

  always_comb begin
    root_shift   = {rem_r[REM_W-3:0], op_r[SQ_W-1 -: 2]};
    root_trial   = REM_W'({root_r, 2'b01});
    root_bit     = root_shift >= root_trial;
    root_rem_nxt = root_bit ? root_shift - root_trial : root_shift;
    root_nxt     = {root_r[DIST_W-2:0], root_bit};

    // Dividend bits are taken MSB first straight from the accumulators.
    div_in      = (state_r == S_DIV1) ? dsum_r[step_r] : ssum_r[step_r];
    div_shift   = {rem_r[REM_W-2:0], div_in};
    div_bit     = div_shift >= REM_W'(count_r);
    div_rem_nxt = div_bit ? div_shift - REM_W'(count_r) : div_shift;
    quo_nxt     = {quo_r[SSUM_W-2:0], div_bit};
  end

  always_comb begin
    out_nxt          = '0;
    out_nxt.distance = dist_r;
    if (final_r) begin
      out_nxt.stats_valid = 1'b1;
      out_nxt.pair_count  = count_r;
      if (count_r != '0) begin
        out_nxt.min_distance  = min_r;
        out_nxt.max_distance  = max_r;
        out_nxt.mean_distance = mean_r;
        out_nxt.rms_distance  = root_r;
      end
      out_nxt.overflowed = ovf_r;
    end
  end

  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign job_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      dsum_r      <= '0;
      ssum_r      <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            op_r    <= job_data.sq;
            final_r <= job_data.final_pair;
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= 6'(ROOT_STEPS - 1);
            state_r <= S_ROOT;
          end
        end
        S_ROOT, S_ROOT2: begin
          // After all steps the rotation brings the operand back unchanged.
          rem_r  <= root_rem_nxt;
          root_r <= root_nxt;
          op_r   <= {op_r[SQ_W-3:0], op_r[SQ_W-1 -: 2]};
          if (step_r == '0) begin
            state_r <= (state_r == S_ROOT) ? S_ACC : S_OUT;
          end else begin
            step_r <= step_r - 6'd1;
          end
        end
        S_ACC: begin
          dist_r <= root_r;
          if (count_r < COUNT_W'(MAX_POINTS)) begin
            count_r <= count_r + COUNT_W'(1);
            if (root_r < min_r) min_r <= root_r;
            if (root_r > max_r) max_r <= root_r;
            dsum_r <= dsum_r + DSUM_W'(root_r);
            ssum_r <= ssum_r + SSUM_W'(op_r);
          end else begin
            ovf_r <= 1'b1;
          end
          if (final_r) begin
            rem_r   <= '0;
            quo_r   <= '0;
            step_r  <= 6'(DSUM_W - 1);
            state_r <= S_DIV1;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV1, S_DIV2: begin
          if (step_r == '0) begin
            if (state_r == S_DIV1) begin
              mean_r  <= quo_nxt[DIST_W-1:0];
              rem_r   <= '0;
              quo_r   <= '0;
              step_r  <= 6'(SSUM_W - 1);
              state_r <= S_DIV2;
            end else begin
              // The mean square never exceeds the largest squared distance.
              op_r    <= quo_nxt[SQ_W-1:0];
              rem_r   <= '0;
              root_r  <= '0;
              step_r  <= 6'(ROOT_STEPS - 1);
              state_r <= S_ROOT2;
            end
          end else begin
            rem_r  <= div_rem_nxt;
            quo_r  <= quo_nxt;
            step_r <= step_r - 6'd1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r   <= out_nxt;
            state_r <= S_IDLE;
            if (final_r) begin
              count_r <= '0;
              min_r   <= '1;
              max_r   <= '0;
              dsum_r  <= '0;
              ssum_r  <= '0;
              ovf_r   <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_busy_no_accept, clk, rst_n, job_ready && state_r != S_IDLE)
  `ASSERT_IMPL(a_count_bound, clk, rst_n, count_r <= COUNT_W'(MAX_POINTS))
  `ASSERT_NEVER(a_min_above_max, clk, rst_n, count_r != '0 && min_r > max_r)
  `ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
endmodule

@@ src/point_distance_statistics.sv @@
// An ordinary pair passes the front register and the two-entry queue; the back
// then runs 17 root steps and accumulates. The pair marked last adds 35 and 52
// division steps and a second 17-step root before its result is registered.
// The sequential back takes a new pair only when idle, once the previous result
// is loaded into the output register, so a stalled result stalls it too.
// Reset (rst_n low, synchronous) empties the queue and clears all statistics.
module point_distance_statistics #(
  parameter int MAX_POINTS = 262144,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pds_pkg::pds_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pds_pkg::pds_out_t  out_data
);
  import pds_pkg::*;

  logic     f_valid, f_ready, q_valid, q_ready;
  pds_job_t f_data, q_data;

  pds_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data));

  pds_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));

  pds_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
    .out_valid, .out_ready, .out_data);
endmodule

@@ tb/tb_point_distance_statistics.sv @@
module tb_point_distance_statistics;
  timeunit 1ns;
  timeprecision 1ps;
  import pds_pkg::*;

  localparam int MAX_PAIRS = 262144;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pds_in_t in_data;
  logic out_valid;
  logic out_ready;
  pds_out_t out_data;

  int mismatch_count = 0;
  int idle_cycles = 0;

  point_distance_statistics uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  class distance_scoreboard;
    logic [18:0] pairs_seen;
    logic [16:0] smallest;
    logic [16:0] largest;
    logic [34:0] dist_total;
    logic [51:0] sq_total;
    logic overflow_seen;
    pds_out_t pending[$];

    function void clear_set();
      pairs_seen = '0;
      smallest = '1;
      largest = '0;
      dist_total = '0;
      sq_total = '0;
      overflow_seen = 1'b0;
    endfunction

    function logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_pair(input pds_in_t p);
      longint dx, dy, dz;
      logic [63:0] sq;
      logic [16:0] d;
      pds_out_t e;
      dx = longint'(p.first_x) - longint'(p.second_x);
      dy = longint'(p.first_y) - longint'(p.second_y);
      dz = longint'(p.first_z) - longint'(p.second_z);
      sq = dx * dx + dy * dy + dz * dz;
      d = 17'(isqrt(sq));
      if (pairs_seen < MAX_PAIRS) begin
        pairs_seen++;
        if (d < smallest) smallest = d;
        if (d > largest) largest = d;
        dist_total += 35'(d);
        sq_total += 52'(sq);
      end else begin
        overflow_seen = 1'b1;
      end
      e = '0;
      e.distance = d;
      if (p.final_pair) begin
        e.stats_valid = 1'b1;
        e.pair_count = pairs_seen;
        if (pairs_seen != 0) begin
          e.min_distance = smallest;
          e.max_distance = largest;
          e.mean_distance = 17'(64'(dist_total) / 64'(pairs_seen));
          e.rms_distance = 17'(isqrt(64'(sq_total) / 64'(pairs_seen)));
        end
        e.overflowed = overflow_seen;
        clear_set();
      end
      pending.push_back(e);
    endfunction

    task check_result(input pds_out_t got);
      pds_out_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no expectation");
        return;
      end
      e = pending.pop_front();
      if (got.distance !== e.distance)
        report_mismatch($sformatf("distance %0d exp %0d", got.distance, e.distance));
      if (got.stats_valid !== e.stats_valid)
        report_mismatch($sformatf("stats_valid %0b exp %0b", got.stats_valid, e.stats_valid));
      if (got.pair_count !== e.pair_count)
        report_mismatch($sformatf("pair_count %0d exp %0d", got.pair_count, e.pair_count));
      if (got.min_distance !== e.min_distance)
        report_mismatch($sformatf("min %0d exp %0d", got.min_distance, e.min_distance));
      if (got.max_distance !== e.max_distance)
        report_mismatch($sformatf("max %0d exp %0d", got.max_distance, e.max_distance));
      if (got.mean_distance !== e.mean_distance)
        report_mismatch($sformatf("mean %0d exp %0d", got.mean_distance, e.mean_distance));
      if (got.rms_distance !== e.rms_distance)
        report_mismatch($sformatf("rms %0d exp %0d", got.rms_distance, e.rms_distance));
      if (got.overflowed !== e.overflowed)
        report_mismatch($sformatf("overflowed %0b exp %0b", got.overflowed, e.overflowed));
    endtask
  endclass

  distance_scoreboard board;
  pds_in_t stimulus[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Accepted transactions are observed at the edge, before the driver updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_pair(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls in runs, sometimes not at all for a while.
  initial begin
    int mode_left;
    int stall_pct;
    out_ready = 1'b0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 200);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
      end
      mode_left--;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic pds_in_t random_pair(input bit last);
    pds_in_t p;
    int kind;
    kind = $urandom_range(0, 3);
    p.first_x = 16'($urandom);
    p.first_y = 16'($urandom);
    p.first_z = 16'($urandom);
    if (kind == 0) begin
      p.second_x = p.first_x + $signed(16'($urandom_range(0, 15)) - 16'sd8);
      p.second_y = p.first_y;
      p.second_z = p.first_z - $signed(16'($urandom_range(0, 3)));
    end else begin
      p.second_x = 16'($urandom);
      p.second_y = 16'($urandom);
      p.second_z = 16'($urandom);
    end
    p.final_pair = last;
    return p;
  endfunction

  function automatic pds_in_t make_pair(input int ax, ay, az, bx, by, bz,
                                        input int last);
    pds_in_t p;
    p.first_x = 16'(ax); p.first_y = 16'(ay); p.first_z = 16'(az);
    p.second_x = 16'(bx); p.second_y = 16'(by); p.second_z = 16'(bz);
    p.final_pair = (last != 0);
    return p;
  endfunction

  task automatic build_stimulus();
    int remaining;
    int set_len;
    // Directed pairs: zero distance, largest distance on the x and y axes and overall,
    // single-pair sets, and a mixed set.
    stimulus.push_back(make_pair(0, 0, 0, 0, 0, 0, 1));
    stimulus.push_back(make_pair(32767, 32767, 32767,
                                 -32768, -32768, -32768, 1));
    stimulus.push_back(make_pair(-32768, 0, 0, 32767, 0, 0, 0));
    stimulus.push_back(make_pair(0, 32767, 0, 0, -32768, 0, 0));
    stimulus.push_back(make_pair(0, 0, -1, 0, 0, 0, 0));
    stimulus.push_back(make_pair(256, 256, 256, 0, 0, 0, 1));
    stimulus.push_back(make_pair(-1, -1, -1, -1, -1, -1, 1));
    stimulus.push_back(make_pair(21845, -21846, 21845,
                                 -21846, 21845, -21846, 0));
    stimulus.push_back(make_pair(3, 4, 0, 0, 0, 0, 0));
    stimulus.push_back(make_pair(-32768, -32768, -32768,
                                 32767, 32767, 32767, 0));
    stimulus.push_back(make_pair(1, 0, 0, 0, 0, 0, 1));
    remaining = 1100;
    while (remaining > 0) begin
      set_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
      if (set_len > remaining) set_len = remaining;
      for (int i = 0; i < set_len; i++)
        stimulus.push_back(random_pair(i == set_len - 1));
      remaining -= set_len;
    end
  endtask

  initial begin
    int burst_left;
    int gap;
    board = new();
    board.clear_set();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = 0;
    while (stimulus.size() > 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 30);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 25);
      end
      in_data <= stimulus.pop_front();
      in_valid <= 1'b1;
      burst_left--;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end
endmodule
